### hw/rtl/bblur_pkg.sv
// bblur_pkg: types, constants and helper functions of the 3x3 rgb box blur
// used by the stream interfaces and by box_blur_3x3_rgb
// depends on nothing
package bblur_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT     = 4096;
	localparam int CFG_WIDTH_BITS = 11;
	localparam int ROW_BITS       = 13;
	localparam int PADDR_BITS     = 3;
	localparam int REG_SEL_BIT    = 2;
	localparam int SUM_BITS       = 12;
	localparam int CNT_BITS       = 4;
	localparam int RECIP_SHIFT    = 20;
	localparam int RECIP_BITS     = 21;
	localparam int PROD_BITS      = SUM_BITS + RECIP_BITS;

	localparam logic [CFG_WIDTH_BITS-1:0] WIDTH_RESET  = CFG_WIDTH_BITS'(1024);
	localparam logic [ROW_BITS-1:0]       HEIGHT_RESET = ROW_BITS'(768);

	// register select, taken from paddr[REG_SEL_BIT]
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	typedef logic [7:0] chan_t;
	// [0] red, [1] green, [2] blue
	typedef chan_t [2:0] rgb_t;

	typedef struct packed {
		logic emit;
		logic top;
		logic bot;
		logic left;
		logic right;
		logic last;
	} tap_info_t;

	// floor(x * recip(n) >> RECIP_SHIFT) == floor(x / n) for x below 4096
	function automatic logic [RECIP_BITS-1:0] recip(input logic [CNT_BITS-1:0] n);
		logic [RECIP_BITS-1:0] r;
		unique case (n)
			4'd1:    r = 21'd1048576;
			4'd2:    r = 21'd524288;
			4'd3:    r = 21'd349526;
			4'd4:    r = 21'd262144;
			4'd6:    r = 21'd174763;
			4'd9:    r = 21'd116509;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### hw/rtl/bblur_in_if.sv
// bblur_in_if: input pixel stream, valid/ready handshake
// depends on bblur_pkg
interface bblur_in_if import bblur_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  kind;
	chan_t red_in;
	chan_t green_in;
	chan_t blue_in;

	modport source (output valid, kind, red_in, green_in, blue_in, input ready);
	modport sink (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

### hw/rtl/bblur_out_if.sv
// bblur_out_if: blurred pixel stream, valid/ready handshake
// depends on bblur_pkg
interface bblur_out_if import bblur_pkg::*; ();
	logic  valid;
	logic  ready;
	chan_t red_out;
	chan_t green_out;
	chan_t blue_out;
	logic  frame_end;

	modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
	modport sink (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

### hw/rtl/box_blur_3x3_rgb.sv
// box_blur_3x3_rgb: 3x3 box blur over an rgb raster stream, top level
// depends on bblur_pkg, bblur_in_if, bblur_out_if
//
// Takes one transaction per clock while the output side is not stalled and
// gives the rounded-half-up mean of each pixel's in-image 3x3 neighbourhood.
// Results trail the input by image_width + 1 transactions; send
// image_width + 1 flush transactions after the last pixel to drain the image.
// A result reaches the output register after its transaction is accepted,
// passing these steps in order: the line stores are read at acceptance, then
// window update, neighbourhood sum, reciprocal multiply and output register.
// The two line stores are read at acceptance and written back from stage 1
// when it advances; a one-pixel-wide image, where consecutive transactions
// hit the same column, takes the write-back data by forwarding.
// Any register write restarts the image. Line stores need no clearing pass.
module box_blur_3x3_rgb import bblur_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	bblur_in_if.sink              pixels,
	bblur_out_if.source           blurred
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WB = ($clog2(MAX_WIDTH + 1) > CFG_WIDTH_BITS) ?
		$clog2(MAX_WIDTH + 1) : CFG_WIDTH_BITS;
	localparam int RB = ROW_BITS + 1;

	// configuration
	logic [CFG_WIDTH_BITS-1:0] width_q;
	logic [ROW_BITS-1:0]       height_q;
	logic                      cfg_wr;

	// positions and handshake
	logic [CW-1:0]       col_q;
	logic [ROW_BITS-1:0] row_q;
	logic                adv;
	logic                accept;

	// front-end decode
	logic [WB-1:0]       wid_raw;
	logic [WB-1:0]       wid_eff;
	logic [ROW_BITS-1:0] hgt_eff;
	logic [CW-1:0]       col_cur;
	logic [WB-1:0]       col_plus;
	logic                col_zero;
	logic [RB-1:0]       r_x;
	logic [RB-1:0]       h_x;
	tap_info_t           info_in;
	rgb_t                pix_in;

	// line stores
	rgb_t upper_mem [MAX_WIDTH];
	rgb_t middle_mem [MAX_WIDTH];

	// stage 1
	logic          v1_q;
	logic [CW-1:0] addr_s1;
	rgb_t          pix_s1;
	tap_info_t     info_s1;
	logic          fwd_s1;
	rgb_t          rd_up_s1;
	rgb_t          rd_mid_s1;
	rgb_t          fwd_up_q;
	rgb_t          fwd_mid_q;
	rgb_t          up_eff;
	rgb_t          mid_eff;

	// window, [column left..right][row top..bottom]
	rgb_t win_q [3][3];

	// stage 2
	logic                v2_q;
	tap_info_t           info_s2;
	logic [2:0]          colv;
	logic [2:0]          rowv;
	logic [1:0]          ncol;
	logic [1:0]          nrow;
	logic [CNT_BITS-1:0] cnt;
	logic [SUM_BITS-1:0] acc [3];

	// stage 3
	logic                  v3_q;
	logic                  last_s3;
	logic [CNT_BITS-1:0]   n_s3;
	logic [SUM_BITS-1:0]   x_s3 [3];
	logic [RECIP_BITS-1:0] rcp;

	// stage 4
	logic                 v4_q;
	logic                 last_s4;
	logic [PROD_BITS-1:0] prod_s4 [3];

	// output register
	logic out_valid_q;
	rgb_t out_pix_q;
	logic out_last_q;

	// apb port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[REG_SEL_BIT])
			REG_WIDTH:  prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[REG_SEL_BIT])
				REG_WIDTH:  width_q  <= pwdata[CFG_WIDTH_BITS-1:0];
				REG_HEIGHT: height_q <= pwdata[ROW_BITS-1:0];
			endcase
		end
	end

	// handshake
	assign adv          = !out_valid_q || blurred.ready;
	assign pixels.ready = adv;
	assign accept       = pixels.valid && adv;

	// position decode
	always_comb begin
		wid_raw = WB'(width_q);
		if (wid_raw == '0) begin
			wid_eff = WB'(1);
		end else if (wid_raw > WB'(MAX_WIDTH)) begin
			wid_eff = WB'(MAX_WIDTH);
		end else begin
			wid_eff = wid_raw;
		end
		if (height_q == '0) begin
			hgt_eff = ROW_BITS'(1);
		end else if (height_q > ROW_BITS'(MAX_HEIGHT)) begin
			hgt_eff = ROW_BITS'(MAX_HEIGHT);
		end else begin
			hgt_eff = height_q;
		end
		col_cur  = (WB'(col_q) >= wid_eff) ? '0 : col_q;
		col_plus = WB'(col_cur) + WB'(1);
		col_zero = (col_cur == '0);
		r_x      = RB'(row_q);
		h_x      = RB'(hgt_eff);

		if (col_zero) begin
			info_in.emit  = (r_x >= RB'(2)) && (r_x <= h_x + RB'(1));
			info_in.top   = (r_x >= RB'(3));
			info_in.bot   = (r_x <= h_x);
			info_in.left  = (wid_eff >= WB'(2));
			info_in.right = 1'b0;
			info_in.last  = (r_x == h_x + RB'(1));
		end else begin
			info_in.emit  = (r_x >= RB'(1)) && (r_x <= h_x);
			info_in.top   = (r_x >= RB'(2));
			info_in.bot   = (r_x < h_x);
			info_in.left  = (col_cur >= CW'(2));
			info_in.right = 1'b1;
			info_in.last  = 1'b0;
		end

		if (pixels.kind == KIND_FLUSH) begin
			pix_in = '0;
		end else begin
			pix_in = {pixels.blue_in, pixels.green_in, pixels.red_in};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (info_in.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_plus >= wid_eff) begin
				col_q <= '0;
				row_q <= (row_q >= ROW_BITS'(MAX_HEIGHT + 1)) ?
					ROW_BITS'(MAX_HEIGHT + 1) : row_q + ROW_BITS'(1);
			end else begin
				col_q <= col_plus[CW-1:0];
			end
		end
	end

	// line stores: read at acceptance, write back from stage 1
	always_ff @(posedge clk) begin
		if (adv && v1_q) begin
			upper_mem[addr_s1] <= mid_eff;
		end
		if (accept) begin
			rd_up_s1 <= upper_mem[col_cur];
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v1_q) begin
			middle_mem[addr_s1] <= pix_s1;
		end
		if (accept) begin
			rd_mid_s1 <= middle_mem[col_cur];
		end
	end

	// stage 1
	assign up_eff  = fwd_s1 ? fwd_up_q : rd_up_s1;
	assign mid_eff = fwd_s1 ? fwd_mid_q : rd_mid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (adv) begin
			v1_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1   <= col_cur;
			pix_s1    <= pix_in;
			info_s1   <= info_in;
			fwd_s1    <= v1_q && (addr_s1 == col_cur);
			fwd_up_q  <= mid_eff;
			fwd_mid_q <= pix_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++) begin
					win_q[j][k] <= '0;
				end
			end
		end else if (adv && v1_q) begin
			win_q[0]    <= win_q[1];
			win_q[1]    <= win_q[2];
			win_q[2][0] <= up_eff;
			win_q[2][1] <= mid_eff;
			win_q[2][2] <= pix_s1;
		end
	end

	// stage 2: masked neighbourhood sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
		end else if (adv) begin
			v2_q <= v1_q && info_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			info_s2 <= info_s1;
		end
	end

	always_comb begin
		colv = {info_s2.right, 1'b1, info_s2.left};
		rowv = {info_s2.bot, 1'b1, info_s2.top};
		ncol = 2'd1 + 2'(info_s2.left) + 2'(info_s2.right);
		nrow = 2'd1 + 2'(info_s2.top) + 2'(info_s2.bot);
		cnt  = CNT_BITS'(ncol) * CNT_BITS'(nrow);
		for (int ch = 0; ch < 3; ch++) begin
			acc[ch] = SUM_BITS'(cnt >> 1);
			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++) begin
					if (colv[j] && rowv[k]) begin
						acc[ch] = acc[ch] + SUM_BITS'(win_q[j][k][ch]);
					end
				end
			end
		end
	end

	// stage 3: divide by reciprocal multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_q <= 1'b0;
		end else if (adv) begin
			v3_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s3 <= info_s2.last;
			n_s3    <= cnt;
			for (int ch = 0; ch < 3; ch++) begin
				x_s3[ch] <= acc[ch];
			end
		end
	end

	assign rcp = recip(n_s3);

	// stage 4
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v4_q <= 1'b0;
		end else if (adv) begin
			v4_q <= v3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s4 <= last_s3;
			for (int ch = 0; ch < 3; ch++) begin
				prod_s4[ch] <= PROD_BITS'(x_s3[ch]) * PROD_BITS'(rcp);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v4_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_last_q <= last_s4;
			for (int ch = 0; ch < 3; ch++) begin
				out_pix_q[ch] <= prod_s4[ch][RECIP_SHIFT +: 8];
			end
		end
	end

	assign blurred.valid     = out_valid_q;
	assign blurred.red_out   = out_pix_q[0];
	assign blurred.green_out = out_pix_q[1];
	assign blurred.blue_out  = out_pix_q[2];
	assign blurred.frame_end = out_last_q;

endmodule
